@@ design/sci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson integrator package
// Shared widths, constants and sequencer states of the cubic integrator.
// ----------------------------------------------------------------------------
package sci_pkg;

   localparam int N_W      = 17;
   localparam int PT_W     = 18;
   localparam int TOL_W    = 16;
   localparam int OUT_W    = 48;
   localparam int ACC_W    = 60;
   localparam int MUL_W    = 32;
   localparam int NUM_W    = 74;
   localparam int DEN_W    = 27;
   localparam int CNT_W    = 7;

   localparam logic [PT_W-1:0]  MAX_N       = 18'd65536;
   localparam logic [25:0]      POLY_OFFSET = 26'd655360;
   localparam logic [TOL_W-1:0] TOL_RESET   = 16'd1;

   localparam logic [0:0] MODE_FIXED  = 1'b0;
   localparam logic [0:0] MODE_DOUBLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_PT,
      ST_SQ,
      ST_HI,
      ST_LO,
      ST_ACC,
      ST_SCALE_LO,
      ST_SCALE_HI,
      ST_RES_GO,
      ST_RES_WAIT,
      ST_DECIDE,
      ST_OUT
   } state_type;

endpackage

@@ design/sci_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson integrator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sci_div import sci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diffv;
   logic             ge;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diffv = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? diffv[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff)
      else $error("Divider remainder reached the divisor.");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("Divider finished without a running division.");

endmodule

@@ design/simpson_cubic_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson cubic integrator
// Integrates x^3 + 10x^2 over a Q8.8 span with composite Simpson's rule.
// ----------------------------------------------------------------------------
// A request transfer on req_* carries the span, the interval count and the
// mode; one result transfer on rsp_* follows per request. The user must write
// the tolerance for the doubling mode through csr_wr_en / csr_wr_data while
// idle; the block itself does not enforce this. One run over n subintervals
// evaluates the 2n+1 sample points, each through ST_PT, ST_SQ, ST_HI, ST_LO
// and ST_ACC, on one shared 32x32 multiplier, with one division in the
// bit-serial divider before the points and one after.
// Mode 0 is one run; the doubling mode runs for n = 2, 4, 8 and so on until
// it converges or n reaches 65536, so its latency is the sum of those runs.
// req_tready is high only while the block is idle. The result sits in an
// output register; a stalled receiver holds it there, and the block still
// takes and works on the next request, waiting only to hand over its result.
// Reset returns the sequencer to idle, drops rsp_tvalid and sets the
// tolerance to one.
// ----------------------------------------------------------------------------
module simpson_cubic_integrator import sci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,   // lower_bound, upper_bound, intervals
   input  logic [0:0]       req_tuser,   // mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata,   // integral, intervals_used
   output logic [0:0]       rsp_tuser,   // not_converged
   input  logic             csr_wr_en,
   input  logic [TOL_W-1:0] csr_wr_data
);

   state_type state_ff, state_in;
   logic [TOL_W-1:0]  tol_ff;
   logic              mode_ff, mode_in;
   logic [15:0]       a_ff, a_in;
   logic [16:0]       span_ff, span_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic              first_ff, first_in;
   logic              flag_ff, flag_in;
   logic [OUT_W-1:0]  res_ff, res_in;
   logic [OUT_W-1:0]  val_ff, val_in;
   logic [23:0]       qs_ff, qs_in;
   logic [PT_W-1:0]   rs_ff, rs_in;
   logic [24:0]       q_ff, q_in;
   logic [PT_W-1:0]   r_ff, r_in;
   logic [PT_W-1:0]   k_ff, k_in;
   logic [23:0]       mx_ff, mx_in;
   logic [23:0]       mp_ff, mp_in;
   logic              pneg_ff, pneg_in;
   logic [30:0]       sq_ff, sq_in;
   logic [38:0]       hi_ff, hi_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [47:0]       lo_ff, lo_in;
   logic [63:0]       prod_ff;
   logic              rsp_tvalid_ff;
   logic [OUT_W-1:0]  rsp_integral_ff;
   logic [N_W-1:0]    rsp_n_ff;
   logic              rsp_flag_ff;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic              rsp_load;
   logic              div_start, div_done;
   logic [NUM_W-1:0]  div_num, div_quot;
   logic [DEN_W-1:0]  div_den, div_rem;

   logic [N_W-1:0]    n_req;
   logic [PT_W-1:0]   n2;
   logic [15:0]       span_mag;
   logic [25:0]       offset, xv, pv, mxw, mpw;
   logic [39:0]       mval;
   logic [40:0]       fval;
   logic [ACC_W-1:0]  term;
   logic [ACC_W-1:0]  smag;
   logic [PT_W:0]     r_sum;
   logic [48:0]       dv, dmag;

   sci_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_comb begin
      n_req    = req_tdata[48:32];
      if (n_req == '0) begin
         n_req = N_W'(1);
      end else if ({1'b0, n_req} > MAX_N) begin
         n_req = MAX_N[N_W-1:0];
      end
      n2       = {n_ff, 1'b0};
      span_mag = span_ff[16] ? 16'(-span_ff) : span_ff[15:0];
      offset   = span_ff[16] ? -{1'b0, q_ff} : {1'b0, q_ff};
      xv       = {{2{a_ff[15]}}, a_ff, 8'b0} + offset;
      pv       = xv + POLY_OFFSET;
      mxw      = xv[25] ? -xv : xv;
      mpw      = pv[25] ? -pv : pv;
      mval     = {1'b0, hi_ff} + {9'b0, prod_ff[46:16]};
      fval     = pneg_ff ? -{1'b0, mval} : {1'b0, mval};
      term     = {{(ACC_W-41){fval[40]}}, fval};
      if (k_ff == '0 || k_ff == n2) begin
         term = term;
      end else if (k_ff[0]) begin
         term = term <<< 2;
      end else begin
         term = term <<< 1;
      end
      smag     = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      r_sum    = {1'b0, r_ff} + {1'b0, rs_ff};
      dv       = {val_ff[OUT_W-1], val_ff} - {res_ff[OUT_W-1], res_ff};
      dmag     = dv[48] ? -dv : dv;
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      a_in      = a_ff;
      span_in   = span_ff;
      n_in      = n_ff;
      first_in  = first_ff;
      flag_in   = flag_ff;
      res_in    = res_ff;
      val_in    = val_ff;
      qs_in     = qs_ff;
      rs_in     = rs_ff;
      q_in      = q_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      mx_in     = mx_ff;
      mp_in     = mp_ff;
      pneg_in   = pneg_ff;
      sq_in     = sq_ff;
      hi_in     = hi_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      lo_in     = lo_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      req_tready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               a_in     = req_tdata[15:0];
               span_in  = {req_tdata[31], req_tdata[31:16]} - {req_tdata[15], req_tdata[15:0]};
               mode_in  = req_tuser[0];
               n_in     = (req_tuser == MODE_DOUBLE) ? N_W'(2) : n_req;
               first_in = 1'b1;
               state_in = ST_STEP_GO;
            end
         end
         ST_STEP_GO: begin
            div_start = 1'b1;
            div_num   = {50'b0, span_mag, 8'b0};
            div_den   = {9'b0, n2};
            state_in  = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (div_done) begin
               qs_in    = div_quot[23:0];
               rs_in    = div_rem[PT_W-1:0];
               q_in     = '0;
               r_in     = '0;
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_PT;
            end
         end
         ST_PT: begin
            mx_in    = mxw[23:0];
            mp_in    = mpw[23:0];
            pneg_in  = pv[25];
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = {8'b0, mx_ff};
            mul_b    = {8'b0, mx_ff};
            state_in = ST_HI;
         end
         ST_HI: begin
            sq_in    = prod_ff[46:16];
            mul_a    = {1'b0, prod_ff[46:16]};
            mul_b    = {24'b0, mp_ff[23:16]};
            state_in = ST_LO;
         end
         ST_LO: begin
            hi_in    = prod_ff[38:0];
            mul_a    = {1'b0, sq_ff};
            mul_b    = {16'b0, mp_ff[15:0]};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + term;
            if (k_ff == n2) begin
               state_in = ST_SCALE_LO;
            end else begin
               k_in = k_ff + PT_W'(1);
               if (r_sum >= {1'b0, n2}) begin
                  r_in = PT_W'(r_sum - {1'b0, n2});
                  q_in = q_ff + {1'b0, qs_ff} + 25'd1;
               end else begin
                  r_in = r_sum[PT_W-1:0];
                  q_in = q_ff + {1'b0, qs_ff};
               end
               state_in = ST_PT;
            end
         end
         ST_SCALE_LO: begin
            neg_in   = acc_ff[ACC_W-1] ^ span_ff[16];
            mul_a    = smag[31:0];
            mul_b    = {16'b0, span_mag};
            state_in = ST_SCALE_HI;
         end
         ST_SCALE_HI: begin
            lo_in    = prod_ff[47:0];
            mul_a    = {8'b0, smag[55:32]};
            mul_b    = {16'b0, span_mag};
            state_in = ST_RES_GO;
         end
         ST_RES_GO: begin
            div_start = 1'b1;
            div_num   = {prod_ff[41:0], 32'b0} + {26'b0, lo_ff};
            div_den   = {n_ff, 10'b0} + {1'b0, n_ff, 9'b0};
            state_in  = ST_RES_WAIT;
         end
         ST_RES_WAIT: begin
            if (div_done) begin
               if (neg_ff) begin
                  if (div_quot > NUM_W'(48'h8000_0000_0000)) begin
                     val_in = 48'h8000_0000_0000;
                  end else begin
                     val_in = -div_quot[OUT_W-1:0];
                  end
               end else begin
                  if (div_quot > NUM_W'(48'h7FFF_FFFF_FFFF)) begin
                     val_in = 48'h7FFF_FFFF_FFFF;
                  end else begin
                     val_in = div_quot[OUT_W-1:0];
                  end
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_in  = val_ff;
            flag_in = 1'b0;
            if (mode_ff == MODE_FIXED) begin
               state_in = ST_OUT;
            end else if (first_ff || dmag > {33'b0, tol_ff}) begin
               if (n2 > MAX_N) begin
                  flag_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  n_in     = n2[N_W-1:0];
                  first_in = 1'b0;
                  state_in = ST_STEP_GO;
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         tol_ff        <= TOL_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      a_ff     <= a_in;
      span_ff  <= span_in;
      n_ff     <= n_in;
      first_ff <= first_in;
      flag_ff  <= flag_in;
      res_ff   <= res_in;
      val_ff   <= val_in;
      qs_ff    <= qs_in;
      rs_ff    <= rs_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      k_ff     <= k_in;
      mx_ff    <= mx_in;
      mp_ff    <= mp_in;
      pneg_ff  <= pneg_in;
      sq_ff    <= sq_in;
      hi_ff    <= hi_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      lo_ff    <= lo_in;
      prod_ff  <= mul_a * mul_b;
      if (rsp_load) begin
         rsp_integral_ff <= res_ff;
         rsp_n_ff        <= n_ff;
         rsp_flag_ff     <= flag_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_n_ff, rsp_integral_ff};
   assign rsp_tuser  = rsp_flag_ff;

   a_point_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> k_ff <= n2)
      else $error("Sample index ran past the end of the span.");

   a_step_rem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PT |-> r_ff < n2)
      else $error("Sample point remainder is not below the point count.");

   a_flag_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_flag_ff |-> {1'b0, rsp_n_ff} == MAX_N)
      else $error("Convergence flag set below the interval limit.");

endmodule

@@ tb/sv/integral_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integral checker
// Watches the request, result and register ports of the Simpson integrator,
// predicts each integral from the accepted request and compares every result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module integral_checker import sci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [55:0]      req_tdata,
   input  logic [0:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [71:0]      rsp_tdata,
   input  logic [0:0]       rsp_tuser,
   input  logic             csr_wr_en,
   input  logic [TOL_W-1:0] csr_wr_data,
   output int               pending,
   output int               errors
);

   typedef struct {
      logic signed [OUT_W-1:0] integral;
      logic [N_W-1:0]          used;
      logic                    not_conv;
   } integral_type;

   integral_type     integral_q[$];
   logic [TOL_W-1:0] tolerance;

   function automatic longint cubic_value(longint x);
      longint mx, sq, p, mp, m;
      mx = (x < 0) ? -x : x;
      sq = (mx * mx) >>> 16;
      p  = x + 64'sd655360;
      mp = (p < 0) ? -p : p;
      m  = sq * (mp >>> 16) + ((sq * (mp & 64'sd65535)) >>> 16);
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint sample_at(longint a, longint span, longint k, longint n);
      return a * 256 + (k * span * 256) / (2 * n);
   endfunction

   function automatic logic signed [OUT_W-1:0] simpson_integral(longint a, longint b,
                                                                longint n);
      logic signed [127:0] acc;
      logic [127:0]        mag, q;
      longint              span, t;
      bit                  neg;
      acc  = '0;
      span = b - a;
      for (longint i = 0; i < n; i++) begin
         t = cubic_value(sample_at(a, span, 2 * i, n))
           + 4 * cubic_value(sample_at(a, span, 2 * i + 1, n))
           + cubic_value(sample_at(a, span, 2 * i + 2, n));
         acc = acc + t;
      end
      neg = acc < 0;
      mag = neg ? -acc : acc;
      if (span < 0) begin
         neg = !neg;
         mag = mag * 128'(-span);
      end else begin
         mag = mag * 128'(span);
      end
      q = mag / 128'(6 * n * 256);
      if (neg) begin
         if (q > (128'd1 << 47)) return {1'b1, 47'd0};
         return -(q[OUT_W-1:0]);
      end
      if (q > ((128'd1 << 47) - 1)) return {1'b0, {47{1'b1}}};
      return q[OUT_W-1:0];
   endfunction

   function automatic integral_type predict_integral(logic [0:0] mode, logic [55:0] data);
      integral_type r;
      longint       a, b, n, nxt, diff;
      a = longint'($signed(data[15:0]));
      b = longint'($signed(data[31:16]));
      r.not_conv = 1'b0;
      if (mode == MODE_FIXED) begin
         n = longint'(data[48:32]);
         if (n == 0) n = 1;
         if (n > 65536) n = 65536;
         r.integral = simpson_integral(a, b, n);
      end else begin
         n = 2;
         r.integral = simpson_integral(a, b, n);
         forever begin
            if (2 * n > 65536) begin
               r.not_conv = 1'b1;
               break;
            end
            n   = 2 * n;
            nxt = longint'(simpson_integral(a, b, n));
            diff = nxt - longint'(r.integral);
            if (diff < 0) diff = -diff;
            r.integral = nxt[OUT_W-1:0];
            if (diff <= longint'(tolerance)) break;
         end
      end
      r.used = n[N_W-1:0];
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t ns: result %s mismatch, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      integral_type e;
      if (reset) begin
         tolerance = TOL_RESET;
         integral_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (integral_q.size() == 0) begin
               $display("%0t ns: result transfer with nothing outstanding", $time);
               errors++;
            end else begin
               e = integral_q.pop_front();
               if ($signed(rsp_tdata[47:0]) != e.integral)
                  report("integral", longint'($signed(rsp_tdata[47:0])),
                         longint'(e.integral));
               if (rsp_tdata[64:48] != e.used)
                  report("intervals_used", longint'(rsp_tdata[64:48]), longint'(e.used));
               if (rsp_tuser[0] != e.not_conv)
                  report("not_converged", longint'(rsp_tuser[0]), longint'(e.not_conv));
            end
         end
         if (req_tvalid && req_tready)
            integral_q.push_back(predict_integral(req_tuser, req_tdata));
         if (csr_wr_en)
            tolerance = csr_wr_data;
      end
      pending = integral_q.size();
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simpson integrator testbench
// Drives directed and random integration requests with random gaps and
// receiver stalls, reprograms the tolerance between phases and reports the
// verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
   import sci_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [55:0]      req_tdata = '0;
   logic [0:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [71:0]      rsp_tdata;
   logic [0:0]       rsp_tuser;
   logic             csr_wr_en = 1'b0;
   logic [TOL_W-1:0] csr_wr_data = '0;
   int               pending, errors;
   bit               calm = 1'b0;
   int               hold_id = 0;
   int               items_sent = 0;

   simpson_cubic_integrator dut (.*);

   integral_checker u_checker (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      repeat (20) #1_000_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // Receiver: random readiness, with a long hold-off whenever one is asked for.
   always @(negedge clock) begin
      int seen_id, hold_left;
      if (hold_id != seen_id) begin
         seen_id   = hold_id;
         hold_left = 600;
      end
      if (reset) rsp_tready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (calm) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) >= 38);
   end

   task automatic send_request(logic [0:0] mode, logic [15:0] lo, logic [15:0] hi,
                               logic [16:0] n);
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, n, hi, lo};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_request(bit bounded);
      logic [15:0] lo, hi;
      logic [16:0] n;
      n = ($urandom_range(0, 99) < 80) ? 17'($urandom_range(0, 24))
                                       : 17'($urandom_range(0, 400));
      if (bounded || $urandom_range(0, 99) < 30) begin
         lo = 16'($urandom_range(0, 2048) - 1024);
         hi = 16'($urandom_range(0, 2048) - 1024);
         send_request(MODE_DOUBLE, lo, hi, 17'($urandom));
      end else begin
         send_request(MODE_FIXED, 16'($urandom), 16'($urandom), n);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero and clamped counts, extreme and reversed spans, doubling mode.
      send_request(MODE_FIXED, 16'd0, 16'd256, 17'd0);
      send_request(MODE_FIXED, 16'h8000, 16'h7fff, 17'd1);
      send_request(MODE_FIXED, 16'd512, -16'sd256, 17'd4);
      send_request(MODE_FIXED, 16'd1000, 16'd1000, 17'd3);
      send_request(MODE_FIXED, 16'h7fff, 16'h8000, 17'd2);
      send_request(MODE_FIXED, 16'h8000, 16'h7fff, 17'h1ffff);
      send_request(MODE_DOUBLE, 16'd0, 16'd256, 17'd0);
      send_request(MODE_DOUBLE, -16'sd256, 16'd256, 17'h1ffff);
      write_tolerance(16'd0);
      send_request(MODE_DOUBLE, 16'h8000, 16'h7fff, 17'd5);
      send_request(MODE_DOUBLE, 16'd256, 16'd256, 17'd9);

      // Random, first without any idling, then with a long receiver hold-off.
      write_tolerance(16'hffff);
      calm = 1'b1;
      repeat (30) random_request(1'b0);
      calm = 1'b0;
      @(posedge clock);
      hold_id++;
      repeat (40) random_request(1'b0);

      // Sender waits for the block to empty before the next phase.
      write_tolerance(16'($urandom_range(16, 4000)));
      repeat (40) random_request(1'b0);
      write_tolerance(TOL_RESET);
      repeat (30) random_request(1'b0);

      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d requests over tolerances 0, 1, 65535 and a random value,", items_sent);
      $display("covering both modes, clamped and zero counts and receiver hold-offs.");
      if (errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
design/sci_pkg.sv
design/sci_div.sv
design/simpson_cubic_integrator.sv
tb/sv/integral_checker.sv
tb/sv/tb.sv
